// ===== sv/cdq_pkg.sv =====
// Shared constants, types and codes for the circular deque block.
`timescale 1ns / 1ps

package cdq_pkg;

   localparam int DEPTH = 128;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int DATA_W = 32;
   localparam int OCC_W = 8;

   localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [2:0] OP_POP_FRONT  = 3'd2;
   localparam logic [2:0] OP_POP_BACK   = 3'd3;
   localparam logic [2:0] OP_PEEK_FRONT = 3'd4;
   localparam logic [2:0] OP_PEEK_BACK  = 3'd5;

   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic [2:0]               operation;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] data_out;
      logic [1:0]               status;
      logic [OCC_W-1:0]         occupancy;
      logic                     is_empty;
      logic                     is_full;
   } rsp_type;

   typedef enum logic [1:0] {
      CTRL_IDLE,
      CTRL_EXEC,
      CTRL_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic load_req;
      logic exec;
      logic load_out;
   } cdq_cmd_type;

   typedef struct packed {
      logic out_free;
   } cdq_sts_type;

endpackage

// ===== sv/cdq_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps

module cdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/cdq_ctrl.sv =====
// Controller state machine sequencing accept, execute and result load.
`timescale 1ns / 1ps

module cdq_ctrl import cdq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  cdq_sts_type sts,
   output cdq_cmd_type cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTRL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      req_stall = 1'b1;
      cmd = '0;
      unique case (state_ff)
         CTRL_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in = CTRL_EXEC;
            end
         end
         CTRL_EXEC: begin
            cmd.exec = 1'b1;
            state_in = CTRL_DONE;
         end
         CTRL_DONE: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               req_stall = 1'b0;
               if (req_valid) begin
                  cmd.load_req = 1'b1;
                  state_in = CTRL_EXEC;
               end else begin
                  state_in = CTRL_IDLE;
               end
            end
         end
         default: begin
            state_in = CTRL_IDLE;
         end
      endcase
   end

endmodule

// ===== sv/cdq_datapath.sv =====
// Deque pointers, element store, status logic and result register.
`timescale 1ns / 1ps

module cdq_datapath import cdq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  req_type     req_data,
   input  cdq_cmd_type cmd,
   output cdq_sts_type sts,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data
);

   logic [2:0]        op_ff;
   logic [DATA_W-1:0] value_ff;

   logic [IDX_W-1:0]  head_ff, head_in;
   logic [IDX_W-1:0]  tail_ff, tail_in;
   logic              empty_ff, empty_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [1:0]        res_status_ff, res_status_in;
   logic              rd_flag_ff, rd_flag_in;

   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff;

   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;
   logic [DATA_W-1:0] rd_data;

   logic [IDX_W-1:0]  head_prev, head_next, tail_prev, tail_next;
   logic              full;

   assign head_prev = (head_ff == '0) ? IDX_W'(DEPTH - 1) : head_ff - 1'b1;
   assign head_next = (head_ff == IDX_W'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign tail_prev = (tail_ff == '0) ? IDX_W'(DEPTH - 1) : tail_ff - 1'b1;
   assign tail_next = (tail_ff == IDX_W'(DEPTH - 1)) ? '0 : tail_ff + 1'b1;
   assign full = (count_ff == CNT_W'(DEPTH));

   cdq_ram #(
      .WIDTH(DATA_W),
      .DEPTH(DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(value_ff),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      empty_in = empty_ff;
      count_in = count_ff;
      res_status_in = res_status_ff;
      rd_flag_in = rd_flag_ff;
      wr_en = 1'b0;
      wr_addr = head_ff;
      rd_en = 1'b0;
      rd_addr = head_ff;
      if (cmd.exec) begin
         res_status_in = ST_DONE;
         rd_flag_in = 1'b0;
         unique case (op_ff)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
               priority if (full) begin
                  res_status_in = ST_FULL;
               end else if (empty_ff) begin
                  head_in = '0;
                  tail_in = '0;
                  empty_in = 1'b0;
                  count_in = CNT_W'(1);
                  wr_en = 1'b1;
                  wr_addr = '0;
               end else if (op_ff == OP_PUSH_FRONT) begin
                  head_in = head_prev;
                  count_in = count_ff + 1'b1;
                  wr_en = 1'b1;
                  wr_addr = head_prev;
               end else begin
                  tail_in = tail_next;
                  count_in = count_ff + 1'b1;
                  wr_en = 1'b1;
                  wr_addr = tail_next;
               end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
               if (empty_ff) begin
                  res_status_in = ST_EMPTY;
               end else begin
                  rd_en = 1'b1;
                  rd_flag_in = 1'b1;
                  rd_addr = (op_ff == OP_POP_FRONT) ? head_ff : tail_ff;
                  priority if (head_ff == tail_ff) begin
                     empty_in = 1'b1;
                     count_in = '0;
                  end else if (op_ff == OP_POP_FRONT) begin
                     head_in = head_next;
                     count_in = count_ff - 1'b1;
                  end else begin
                     tail_in = tail_prev;
                     count_in = count_ff - 1'b1;
                  end
               end
            end
            OP_PEEK_FRONT, OP_PEEK_BACK: begin
               if (empty_ff) begin
                  res_status_in = ST_EMPTY;
               end else begin
                  rd_en = 1'b1;
                  rd_flag_in = 1'b1;
                  rd_addr = (op_ff == OP_PEEK_FRONT) ? head_ff : tail_ff;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         empty_ff <= 1'b1;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         empty_ff <= empty_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff <= req_data.operation;
         value_ff <= req_data.value;
      end
      res_status_ff <= res_status_in;
      rd_flag_ff <= rd_flag_in;
      if (cmd.load_out) begin
         rsp_ff.data_out <= rd_flag_ff ? rd_data : '0;
         rsp_ff.status <= res_status_ff;
         rsp_ff.occupancy <= OCC_W'(count_ff);
         rsp_ff.is_empty <= empty_ff;
         rsp_ff.is_full <= full;
      end
   end

   assign rsp_valid_in = cmd.load_out | (rsp_valid_ff & rsp_stall);
   assign sts.out_free = ~rsp_valid_ff | ~rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

// ===== sv/circular_deque.sv =====
// Top level of the circular deque: controller, datapath and element store.
//
//   Channel   Ports                           Carries
//   request   req_valid, req_stall, req_data  operation and value
//   response  rsp_valid, rsp_stall, rsp_data  data_out, status, occupancy, flags
//
// Each transaction first updates pointers and issues the store access, then the
// registered store read data reaches the result register once the output is free.
// A new transaction is taken in the cycle its predecessor's result is loaded.
// Reset empties the deque at once; store contents are not cleared.
// A stalled response holds its result; the next one waits behind it.
`timescale 1ns / 1ps

module circular_deque import cdq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   cdq_cmd_type cmd;
   cdq_sts_type sts;

   cdq_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .sts      (sts),
      .cmd      (cmd)
   );

   cdq_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

endmodule

// ===== tb/sv/tb_circular_deque.sv =====
// Self-checking testbench for circular_deque: directed and random traffic vs a shadow deque.
`timescale 1ns / 1ps
module tb_circular_deque;
   import cdq_pkg::*;

   localparam logic [2:0] OP_UNUSED_LO = 3'd6;
   localparam logic [2:0] OP_UNUSED_HI = 3'd7;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 20;
   localparam int CYCLE_LIMIT   = 200000;

   typedef struct {
      req_type item;
      int      phase;
      bit      drain;
      bit      hold;
   } deque_cmd_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   deque_cmd_type pending_q[$];
   rsp_type       expected_q[$];

   logic signed [DATA_W-1:0] shadow_mem [DEPTH];
   logic [IDX_W-1:0]         shadow_front = '0;
   logic [IDX_W-1:0]         shadow_back  = '0;
   logic                     shadow_empty = 1'b1;

   int sent_count     = 0;
   int resp_count     = 0;
   int mismatch_count = 0;
   int full_count     = 0;
   int empty_count    = 0;
   int cycle_count    = 0;
   int idle_phase     = 0;
   int hold_requests  = 0;
   int hold_served    = 0;
   int hold_left      = 0;

   circular_deque DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial forever #5 clock = ~clock;

   function automatic logic [IDX_W-1:0] index_up(logic [IDX_W-1:0] i);
      return (int'(i) == DEPTH - 1) ? '0 : i + 1'b1;
   endfunction

   function automatic logic [IDX_W-1:0] index_down(logic [IDX_W-1:0] i);
      return (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
   endfunction

   function automatic int held_count();
      int span;
      if (shadow_empty)
         return 0;
      span = int'(shadow_back) - int'(shadow_front);
      if (span < 0)
         span += DEPTH;
      return span + 1;
   endfunction

   function automatic rsp_type apply_deque_op(req_type r);
      rsp_type res;
      int      held;
      res = '0;
      res.status = ST_DONE;
      held = held_count();
      case (r.operation)
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (held == DEPTH) begin
               res.status = ST_FULL;
            end else if (shadow_empty) begin
               shadow_front = '0;
               shadow_back = '0;
               shadow_empty = 1'b0;
               shadow_mem[0] = r.value;
            end else if (r.operation == OP_PUSH_FRONT) begin
               shadow_front = index_down(shadow_front);
               shadow_mem[shadow_front] = r.value;
            end else begin
               shadow_back = index_up(shadow_back);
               shadow_mem[shadow_back] = r.value;
            end
         end
         OP_POP_FRONT, OP_POP_BACK: begin
            if (shadow_empty) begin
               res.status = ST_EMPTY;
            end else if (shadow_front == shadow_back) begin
               res.data_out = shadow_mem[shadow_front];
               shadow_empty = 1'b1;
            end else if (r.operation == OP_POP_FRONT) begin
               res.data_out = shadow_mem[shadow_front];
               shadow_front = index_up(shadow_front);
            end else begin
               res.data_out = shadow_mem[shadow_back];
               shadow_back = index_down(shadow_back);
            end
         end
         OP_PEEK_FRONT, OP_PEEK_BACK: begin
            if (shadow_empty)
               res.status = ST_EMPTY;
            else if (r.operation == OP_PEEK_FRONT)
               res.data_out = shadow_mem[shadow_front];
            else
               res.data_out = shadow_mem[shadow_back];
         end
         default: ;
      endcase
      held = held_count();
      res.occupancy = OCC_W'(held);
      res.is_empty = shadow_empty;
      res.is_full = (held == DEPTH);
      return res;
   endfunction

   function automatic void queue_cmd(logic [2:0] op, logic [DATA_W-1:0] value,
                                     bit drain = 1'b0, bit hold = 1'b0);
      deque_cmd_type c;
      c.item.operation = op;
      c.item.value = value;
      c.phase = 0;
      c.drain = drain;
      c.hold = hold;
      pending_q.push_back(c);
   endfunction

   task automatic report_mismatch(string what, logic [DATA_W-1:0] got,
                                  logic [DATA_W-1:0] want);
      $display("mismatch on %s at result %0d: got %0h, want %0h",
               what, resp_count, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : driver
      deque_cmd_type next_cmd;
      if (reset) begin
         req_valid <= 1'b0;
         req_data <= '0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_q.push_back(apply_deque_op(req_data));
            sent_count++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_q.size() != 0 && !(pending_q[0].drain && sent_count != resp_count)
                && $urandom_range(99) >= (pending_q[0].phase == 0 ? 33 :
                                          pending_q[0].phase == 1 ? 79 : 0)) begin
               next_cmd = pending_q.pop_front();
               req_valid <= 1'b1;
               req_data <= next_cmd.item;
               idle_phase <= next_cmd.phase;
               if (next_cmd.hold)
                  hold_requests <= hold_requests + 1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : receiver
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (hold_served != hold_requests) begin
         hold_served++;
         hold_left = HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < (idle_phase == 0 ? 79 : idle_phase == 1 ? 33 : 0));
      end
   end

   always @(posedge clock) begin : monitor
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         resp_count <= resp_count + 1;
         if (expected_q.size() == 0) begin
            report_mismatch("unexpected result", rsp_data.data_out, '0);
         end else begin
            want = expected_q.pop_front();
            if (want.status == ST_FULL)
               full_count++;
            if (want.status == ST_EMPTY)
               empty_count++;
            if (rsp_data.data_out !== want.data_out)
               report_mismatch("data_out", rsp_data.data_out, want.data_out);
            if (rsp_data.status !== want.status)
               report_mismatch("status", DATA_W'(rsp_data.status), DATA_W'(want.status));
            if (rsp_data.occupancy !== want.occupancy)
               report_mismatch("occupancy", DATA_W'(rsp_data.occupancy),
                               DATA_W'(want.occupancy));
            if (rsp_data.is_empty !== want.is_empty)
               report_mismatch("is_empty", DATA_W'(rsp_data.is_empty),
                               DATA_W'(want.is_empty));
            if (rsp_data.is_full !== want.is_full)
               report_mismatch("is_full", DATA_W'(rsp_data.is_full), DATA_W'(want.is_full));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      int         pushes;
      int         pops;
      bit         hold_done;
      bit         hold_now;
      logic [2:0] op;

      queue_cmd(OP_POP_FRONT, $urandom);
      queue_cmd(OP_POP_BACK, $urandom);
      queue_cmd(OP_PEEK_FRONT, $urandom);
      queue_cmd(OP_PEEK_BACK, $urandom);
      queue_cmd(OP_UNUSED_LO, $urandom);
      queue_cmd(OP_PUSH_BACK, 32'h7FFF_FFFF);
      queue_cmd(OP_PUSH_FRONT, 32'h8000_0000);
      queue_cmd(OP_PUSH_BACK, 32'h0000_0000);
      queue_cmd(OP_PUSH_FRONT, 32'hFFFF_FFFF);
      queue_cmd(OP_PEEK_FRONT, $urandom);
      queue_cmd(OP_PEEK_BACK, $urandom);
      queue_cmd(OP_UNUSED_HI, $urandom);
      queue_cmd(OP_POP_BACK, $urandom);
      queue_cmd(OP_POP_FRONT, $urandom);
      queue_cmd(OP_POP_BACK, $urandom);
      queue_cmd(OP_PEEK_BACK, $urandom);
      queue_cmd(OP_POP_FRONT, $urandom);
      queue_cmd(OP_POP_BACK, $urandom);
      queue_cmd(OP_PUSH_FRONT, 32'h5555_5555);
      queue_cmd(OP_POP_BACK, $urandom);
      queue_cmd(OP_PUSH_BACK, 32'hAAAA_AAAA);
      queue_cmd(OP_POP_FRONT, $urandom);

      // fill past full, then drain past empty, then a free mix
      pushes = 0;
      hold_done = 1'b0;
      while (pushes < DEPTH + 6) begin
         if ($urandom_range(99) < 85) begin
            op = $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
            pushes++;
         end else begin
            case ($urandom_range(3))
               0: op = OP_PEEK_FRONT;
               1: op = OP_PEEK_BACK;
               2: op = OP_UNUSED_LO;
               default: op = OP_UNUSED_HI;
            endcase
         end
         hold_now = (pushes == 40) && !hold_done;
         hold_done |= hold_now;
         queue_cmd(op, $urandom, pushes == 1 && op != OP_PEEK_FRONT, hold_now);
      end
      pops = 0;
      while (pops < DEPTH + 6) begin
         if ($urandom_range(99) < 85) begin
            op = $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
            pops++;
         end else begin
            op = $urandom_range(1) ? OP_PEEK_FRONT : OP_PEEK_BACK;
         end
         queue_cmd(op, $urandom);
      end
      for (int i = 0; i < 100; i++)
         queue_cmd(3'($urandom_range(7)), $urandom, i == 0);

      foreach (pending_q[i])
         pending_q[i].phase = i * 3 / pending_q.size();

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      do
         @(negedge clock);
      while (pending_q.size() != 0 || req_valid || sent_count != resp_count);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (expected_q.size() != 0)
         report_mismatch("leftover expectations", expected_q.size(), '0);

      $display("%0d transactions checked: %0d rejected as full, %0d answered empty",
               resp_count, full_count, empty_count);
      $display("three idle profiles, a %0d-cycle response hold and a full drain pause",
               HOLD_CYCLES);
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

// ===== circular_deque.f =====
sv/cdq_pkg.sv
sv/cdq_ram.sv
sv/cdq_ctrl.sv
sv/cdq_datapath.sv
sv/circular_deque.sv
tb/sv/tb_circular_deque.sv
